[rtl/olist_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list package
// Shared constants, codes and word types for the ordered list block.
// ----------------------------------------------------------------------------
package olist_pkg;

	// Number of entries the list can hold.
	localparam int CAPACITY = 32;

	localparam int VAL_W   = 32;
	localparam int POS_W   = 6;
	localparam int FUNC_W  = 2;
	localparam int STAT_W  = 2;
	localparam int ECNT_W  = 6;
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	// Operation codes.
	localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd3;

	// What a storage cell does in a cycle.
	typedef enum logic [1:0] {
		CELL_HOLD  = 2'd0,
		CELL_SHIFT = 2'd1,
		CELL_LOAD  = 2'd2
	} cell_op_t;

	typedef struct packed {
		logic [FUNC_W-1:0]       func;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} olist_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] entry_value;
		logic [ECNT_W-1:0]       entry_count;
		logic                    last;
	} olist_rsp_t;

endpackage

[rtl/ordered_list_delete_at_position_top.sv]
// An append or a delete gives its single result word, registered, in the cycle after acceptance.
// Appends and deletes are taken in every cycle while busy is low; a dump gives one word
// per cycle, one for each entry, and holds busy after acceptance until its last word.
// The rate is set by the one output register, which the rotating cell chain feeds.
// Reset clears the entry count, the dump sequencer and the strobe; the cells are not reset.
// The receiver cannot stall: every result word is taken in the cycle it is shown.
// ----------------------------------------------------------------------------
// Ordered list with delete at position
// Bounded list of signed values in a chain of shifting cells, with append,
// delete at a 1-based position and a dump of the whole list.
// ----------------------------------------------------------------------------
module ordered_list_delete_at_position_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  olist_pkg::olist_cmd_t cmd,
	output logic                  busy,
	output logic                  strobe,
	output olist_pkg::olist_rsp_t rsp
);
	import olist_pkg::*;

	// Dump sequencer states.
	typedef enum logic [1:0] {
		SEQ_IDLE = 2'b01,
		SEQ_DUMP = 2'b10
	} seq_state_t;

	seq_state_t              state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        idx;
	logic                    strobe_q, strobe_d;
	olist_rsp_t              rsp_q, rsp_d;

	logic                    accept;
	logic                    full;
	logic                    del_ok;
	logic                    dump_go;
	logic                    dump_last;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        cnt_ext;
	logic signed [VAL_W-1:0] load_val;
	cell_op_t                cell_op [CAPACITY];
	logic signed [VAL_W-1:0] cell_val [CAPACITY];

	// The chain of cells. Each cell takes its neighbour towards the tail when
	// a gap is closed or the list is rotated; the last cell sees zero.
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic signed [VAL_W-1:0] nbr;
		if (g == CAPACITY - 1) begin : g_end
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_val[g + 1];
		end
		olist_cell u_cell (
			.clk      (clk),
			.op       (cell_op[g]),
			.next_val (nbr),
			.load_val (load_val),
			.val      (cell_val[g])
		);
	end

	assign busy = (state_q == SEQ_DUMP);

	always_comb begin
		accept  = start && !busy;
		full    = (count_q == CNT_W'(CAPACITY));
		pos_ext = CMP_W'(cmd.position);
		cnt_ext = CMP_W'(count_q);
		del_ok  = (cmd.position != '0) && (pos_ext <= cnt_ext);

		// A dump word leaves in the cycle a dump is accepted and in every
		// cycle of the dump state. The list rotates by one place each time,
		// so the head cell always holds the next entry, and after a full
		// pass the list is back in its original order.
		dump_go   = busy || (accept && (cmd.func == FUNC_DUMP) && (count_q != '0));
		idx       = busy ? idx_q : '0;
		dump_last = ((CNT_W'(idx) + CNT_W'(1)) == count_q);

		count_d  = count_q;
		strobe_d = 1'b0;
		rsp_d    = '0;
		load_val = cmd.value;
		state_d  = state_q;
		for (int i = 0; i < CAPACITY; i++) begin
			cell_op[i] = CELL_HOLD;
		end

		if (dump_go) begin
			strobe_d          = 1'b1;
			rsp_d.status      = STAT_OK;
			rsp_d.entry_value = cell_val[0];
			rsp_d.entry_count = ECNT_W'(count_q);
			rsp_d.last        = dump_last;
			load_val          = cell_val[0];
			state_d           = dump_last ? SEQ_IDLE : SEQ_DUMP;
			for (int i = 0; i < CAPACITY; i++) begin
				if (CMP_W'(i + 1) < cnt_ext) begin
					cell_op[i] = CELL_SHIFT;
				end else if (CMP_W'(i + 1) == cnt_ext) begin
					cell_op[i] = CELL_LOAD;
				end
			end
		end else if (accept) begin
			unique case (cmd.func)
				FUNC_APPEND: begin
					strobe_d   = 1'b1;
					rsp_d.last = 1'b1;
					if (full) begin
						rsp_d.status      = STAT_FULL;
						rsp_d.entry_count = ECNT_W'(count_q);
					end else begin
						count_d           = count_q + CNT_W'(1);
						rsp_d.status      = STAT_OK;
						rsp_d.entry_count = ECNT_W'(count_d);
						for (int i = 0; i < CAPACITY; i++) begin
							if (CMP_W'(i) == cnt_ext) begin
								cell_op[i] = CELL_LOAD;
							end
						end
					end
				end
				FUNC_DELETE: begin
					strobe_d   = 1'b1;
					rsp_d.last = 1'b1;
					if (del_ok) begin
						count_d           = count_q - CNT_W'(1);
						rsp_d.status      = STAT_OK;
						rsp_d.entry_count = ECNT_W'(count_d);
						// Cells from the deleted place to the one before the
						// tail take their neighbour, closing the gap.
						for (int i = 0; i < CAPACITY; i++) begin
							if ((CMP_W'(i + 1) >= pos_ext) && (CMP_W'(i + 1) < cnt_ext)) begin
								cell_op[i] = CELL_SHIFT;
							end
						end
					end else begin
						rsp_d.status      = STAT_BADPOS;
						rsp_d.entry_count = ECNT_W'(count_q);
					end
				end
				FUNC_DUMP: begin
					// Only an empty list reaches here; a filled one is a dump_go.
					strobe_d          = 1'b1;
					rsp_d.status      = STAT_EMPTY;
					rsp_d.entry_count = '0;
					rsp_d.last        = 1'b1;
				end
				default: begin
					// The unused operation code gives no word and changes nothing.
					strobe_d = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SEQ_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
			if (dump_go) begin
				idx_q <= idx + IDX_W'(1);
			end
		end
	end

	// The result payload needs no reset; the strobe qualifies it.
	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
	end

	assign strobe = strobe_q;
	assign rsp    = rsp_q;

	// While a dump runs, a word was produced in the cycle before.
	a_dump_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe)
		else $error("dump in progress without a result word");

	// A word that is not the last of its item only appears within a dump.
	a_notlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !rsp.last) |-> busy)
		else $error("non-final word outside a dump");

	// The entry count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// A list-full word is only given when the list really is full.
	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && (rsp.status == STAT_FULL)) |-> full)
		else $error("full status on a list with room");

	// The count moves by at most one per cycle and never during a dump.
	a_count_dump: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(count_q))
		else $error("entry count changed during a dump");

endmodule

[rtl/olist_cell.sv]
// ----------------------------------------------------------------------------
// Ordered list storage cell
// Holds one entry; keeps it, takes its neighbour's entry or loads a new one.
// ----------------------------------------------------------------------------
module olist_cell (
	input  logic                            clk,
	input  olist_pkg::cell_op_t             op,
	input  logic signed [olist_pkg::VAL_W-1:0] next_val,
	input  logic signed [olist_pkg::VAL_W-1:0] load_val,
	output logic signed [olist_pkg::VAL_W-1:0] val
);
	import olist_pkg::*;

	logic signed [VAL_W-1:0] val_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_SHIFT: val_q <= next_val;
			CELL_LOAD:  val_q <= load_val;
			default:    val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule
